[rtl/qvr_pkg.sv]
// shared constants and types for the quaternion vector rotate block
// depends on nothing; used by qvr_div and quaternion_vector_rotate
package qvr_pkg;

  // default vector component width
  localparam int VEC_WIDTH = 16;

  // quaternion component width (signed fixed point)
  localparam int QUAT_W = 16;

  // |q|^2 of four 16-bit signed components fits 33 unsigned bits
  localparam int DEN_W = 33;

  // status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

  // sideband that travels beside the divider lanes
  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } side_t;

endpackage

[rtl/qvr_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// and round-half-up bit from the final remainder; depends on qvr_pkg
module qvr_div #(
  parameter int NUM_W = 54,
  parameter int QB    = 17
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [NUM_W-1:0]          num_i,
  input  logic [qvr_pkg::DEN_W-1:0] den_i,
  output logic [QB-1:0]             quot_o,
  output logic                      ovf_o,
  output logic                      rnd_o
);

  localparam int CW = NUM_W + 1;

  logic [CW-1:0]             rem_q [0:QB];
  logic [qvr_pkg::DEN_W-1:0] den_q [0:QB];
  logic [QB-1:0]             quo_q [0:QB];
  logic                      ovf_q [0:QB];

  // entry stage: quotient too large for QB bits means overflow
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= CW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= CW'(num_i) >= (CW'(den_i) << QB);
    end
  end

  // one quotient bit per stage, msb first
  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int SH = QB - 1 - j;
    logic [CW-1:0] dsh;
    logic          ge;
    logic [QB-1:0] quo_d;

    always_comb begin
      dsh       = CW'(den_q[j]) << SH;
      ge        = rem_q[j] >= dsh;
      quo_d     = quo_q[j];
      quo_d[SH] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? (rem_q[j] - dsh) : rem_q[j];
        den_q[j+1] <= den_q[j];
        quo_q[j+1] <= quo_d;
        ovf_q[j+1] <= ovf_q[j];
      end
    end
  end

  // round half away from zero: 2*rem >= den
  assign quot_o = quo_q[QB];
  assign ovf_o  = ovf_q[QB];
  assign rnd_o  = {rem_q[QB][CW-2:0], 1'b0} >= CW'(den_q[QB]);

endmodule

[rtl/quaternion_vector_rotate.sv]
// quaternion sandwich-product vector rotation, v' = q (0,v) q* / |q|^2
// depends on qvr_pkg and qvr_div
//
// channel   dir  tdata (low bit up)                           tuser
// s_axis    in   quat_w, quat_x, quat_y, quat_z, vec_x/y/z    -
// m_axis    out  rot_x, rot_y, rot_z                          status
//
// one word accepted per cycle while m_axis is not stalled; the divider
// produces one quotient bit per stage
// four arithmetic stages, VEC_WIDTH + 2 divider stages, one output register
// async active-low reset clears the valid bits only
// a stall on m_axis freezes the whole pipeline; nothing is dropped or repeated
module quaternion_vector_rotate #(
  parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, zero pad
  input  logic [((4*qvr_pkg::QUAT_W+3*VEC_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // rot_x, rot_y, rot_z, zero pad
  output logic [((3*VEC_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [qvr_pkg::STATUS_W-1:0] m_axis_tuser
);

  localparam int QW    = qvr_pkg::QUAT_W;
  localparam int DW    = qvr_pkg::DEN_W;
  localparam int VW    = VEC_WIDTH;
  localparam int SQ_W  = 2 * QW - 1;
  localparam int PP_W  = QW + VW;
  localparam int A_W   = DW + 1;
  localparam int T1_W  = A_W + VW;
  localparam int T2_W  = QW + PP_W + 1;
  localparam int T3_W  = QW + PP_W + 2;
  localparam int NUM_W = VW + 38;
  localparam int QB    = VW + 1;
  localparam int NST   = 4 + QB + 1;
  localparam int OUT_TW = ((3*VW+7)/8)*8;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // valid bits of all stages
  logic [NST-1:0] vld_q;
  logic           out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NST-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[NST-1];
    end
  end

  // input unpack
  logic signed [QW-1:0] w_in;
  logic signed [QW-1:0] u_in [3];
  logic signed [VW-1:0] v_in [3];

  always_comb begin
    w_in = s_axis_tdata[QW-1:0];
    for (int k = 0; k < 3; k++) begin
      u_in[k] = s_axis_tdata[QW*(k+1) +: QW];
      v_in[k] = s_axis_tdata[4*QW + VW*k +: VW];
    end
  end

  // stage a: squares and all u_i * v_j products
  logic signed [QW-1:0]   w_a_q;
  logic signed [QW-1:0]   u_a_q [3];
  logic signed [VW-1:0]   v_a_q [3];
  logic        [SQ_W-1:0] sq_a_q [4];
  logic signed [PP_W-1:0] pp_a_q [3][3];
  logic signed [2*QW-1:0] sq_full [4];

  always_comb begin
    sq_full[0] = (2*QW)'(w_in) * (2*QW)'(w_in);
    for (int k = 0; k < 3; k++) begin
      sq_full[k+1] = (2*QW)'(u_in[k]) * (2*QW)'(u_in[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_a_q <= w_in;
      for (int k = 0; k < 4; k++) begin
        sq_a_q[k] <= sq_full[k][SQ_W-1:0];
      end
      for (int i = 0; i < 3; i++) begin
        u_a_q[i] <= u_in[i];
        v_a_q[i] <= v_in[i];
        for (int j = 0; j < 3; j++) begin
          pp_a_q[i][j] <= PP_W'(u_in[i]) * PP_W'(v_in[j]);
        end
      end
    end
  end

  // stage b: norm, w^2 - |u|^2, cross and dot products
  logic        [31:0]     uu_b;
  logic signed [QW-1:0]   w_b_q;
  logic signed [QW-1:0]   u_b_q [3];
  logic signed [VW-1:0]   v_b_q [3];
  logic        [DW-1:0]   den_b_q;
  logic signed [A_W-1:0]  a_b_q;
  logic signed [PP_W:0]   c_b_q [3];
  logic signed [PP_W+1:0] s_b_q;

  assign uu_b = 32'(sq_a_q[1]) + 32'(sq_a_q[2]) + 32'(sq_a_q[3]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_b_q   <= w_a_q;
      u_b_q   <= u_a_q;
      v_b_q   <= v_a_q;
      den_b_q <= DW'(sq_a_q[0]) + DW'(uu_b);
      a_b_q   <= $signed(A_W'(sq_a_q[0]) - A_W'(uu_b));
      c_b_q[0] <= (PP_W+1)'(pp_a_q[1][2]) - (PP_W+1)'(pp_a_q[2][1]);
      c_b_q[1] <= (PP_W+1)'(pp_a_q[2][0]) - (PP_W+1)'(pp_a_q[0][2]);
      c_b_q[2] <= (PP_W+1)'(pp_a_q[0][1]) - (PP_W+1)'(pp_a_q[1][0]);
      s_b_q   <= (PP_W+2)'(pp_a_q[0][0]) + (PP_W+2)'(pp_a_q[1][1])
               + (PP_W+2)'(pp_a_q[2][2]);
    end
  end

  // stage c: the three numerator terms of each lane
  logic signed [T1_W-1:0] t1_c_q [3];
  logic signed [T2_W-1:0] t2_c_q [3];
  logic signed [T3_W-1:0] t3_c_q [3];
  logic        [DW-1:0]   den_c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_c_q <= den_b_q;
      for (int k = 0; k < 3; k++) begin
        t1_c_q[k] <= T1_W'(a_b_q) * T1_W'(v_b_q[k]);
        t2_c_q[k] <= T2_W'(w_b_q) * T2_W'(c_b_q[k]);
        t3_c_q[k] <= T3_W'(s_b_q) * T3_W'(u_b_q[k]);
      end
    end
  end

  // stage d: numerator sum, sign and magnitude
  logic signed [NUM_W-1:0] num_d [3];
  logic        [NUM_W-1:0] mag_d_q [3];
  logic        [DW-1:0]    den_d_q;
  qvr_pkg::side_t          side_d_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_d[k] = NUM_W'(t1_c_q[k]) + (NUM_W'(t2_c_q[k]) <<< 1)
               + (NUM_W'(t3_c_q[k]) <<< 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_d_q       <= den_c_q;
      side_d_q.zero <= den_c_q == '0;
      for (int k = 0; k < 3; k++) begin
        side_d_q.neg[k] <= num_d[k][NUM_W-1];
        mag_d_q[k]      <= num_d[k][NUM_W-1] ? NUM_W'(-num_d[k]) : NUM_W'(num_d[k]);
      end
    end
  end

  // divider lanes and sideband alongside
  logic [QB-1:0] quot [3];
  logic [2:0]    ovf;
  logic [2:0]    rnd;
  qvr_pkg::side_t side_q [0:QB];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    qvr_div #(
      .NUM_W (NUM_W),
      .QB    (QB)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (mag_d_q[k]),
      .den_i  (den_d_q),
      .quot_o (quot[k]),
      .ovf_o  (ovf[k]),
      .rnd_o  (rnd[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d_q;
      for (int j = 0; j < QB; j++) begin
        side_q[j+1] <= side_q[j];
      end
    end
  end

  // rounding, sign and saturation
  localparam logic [QB:0] MAX_NEG = (QB+1)'(1) << (VW-1);
  localparam logic [QB:0] MAX_POS = MAX_NEG - (QB+1)'(1);

  logic [QB:0]   qr [3];
  logic [VW-1:0] res [3];
  logic [2:0]    sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qr[k] = (QB+1)'(quot[k]) + (QB+1)'(rnd[k]);
      if (side_q[QB].neg[k]) begin
        sat[k] = ovf[k] || (qr[k] > MAX_NEG);
        res[k] = sat[k] ? {1'b1, {(VW-1){1'b0}}} : VW'(-qr[k]);
      end else begin
        sat[k] = ovf[k] || (qr[k] > MAX_POS);
        res[k] = sat[k] ? {1'b0, {(VW-1){1'b1}}} : VW'(qr[k]);
      end
    end
  end

  // output register
  logic [VW-1:0]                rot_q [3];
  logic [qvr_pkg::STATUS_W-1:0] status_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rot_q[k] <= side_q[QB].zero ? '0 : res[k];
      end
      if (side_q[QB].zero) begin
        status_q <= qvr_pkg::ST_ZERO;
      end else if (sat != '0) begin
        status_q <= qvr_pkg::ST_SAT;
      end else begin
        status_q <= qvr_pkg::ST_OK;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TW'({rot_q[2], rot_q[1], rot_q[0]});
  assign m_axis_tuser  = status_q;

  // zero quaternion gives an all-zero vector
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && status_q == qvr_pkg::ST_ZERO |->
      rot_q[0] == '0 && rot_q[1] == '0 && rot_q[2] == '0)
    else $error("zero quaternion with nonzero output");

  // saturation status means some component sits at a limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && status_q == qvr_pkg::ST_SAT |->
      rot_q[0] == {1'b0, {(VW-1){1'b1}}} || rot_q[0] == {1'b1, {(VW-1){1'b0}}} ||
      rot_q[1] == {1'b0, {(VW-1){1'b1}}} || rot_q[1] == {1'b1, {(VW-1){1'b0}}} ||
      rot_q[2] == {1'b0, {(VW-1){1'b1}}} || rot_q[2] == {1'b1, {(VW-1){1'b0}}})
    else $error("saturation flagged with no component at a limit");

  // a valid output never carries the unused status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> status_q == qvr_pkg::ST_OK || status_q == qvr_pkg::ST_SAT ||
      status_q == qvr_pkg::ST_ZERO)
    else $error("undefined status code");

  // a stall freezes every stage valid bit in vld_q
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

endmodule
